// ===== rtl/cmr_pkg.sv =====
package cmr_pkg;

  localparam int MATRIX_HEIGHT = 8;
  localparam int MATRIX_WIDTH  = 32;

  localparam logic OP_RENDER = 1'b0;
  localparam logic OP_EVENT  = 1'b1;

  localparam logic [2:0] COLOR_GREEN  = 3'd0;
  localparam logic [2:0] COLOR_BLUE   = 3'd1;
  localparam logic [2:0] COLOR_RED    = 3'd2;
  localparam logic [2:0] COLOR_CYAN   = 3'd3;
  localparam logic [2:0] COLOR_YELLOW = 3'd4;

  localparam logic [7:0] CHAR_DASH = 8'h2D;
  localparam logic [7:0] CHAR_X    = 8'h58;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [2:0] WDAY_SUNDAY   = 3'd0;
  localparam logic [2:0] WDAY_SATURDAY = 3'd6;
  localparam logic [4:0] FIRST_COLUMN  = 5'd7;
  localparam logic [2:0] FIRST_ROW     = 3'd6;

  typedef struct packed {
    logic        opcode;
    logic [13:0] year_value;
    logic [3:0]  month_value;
    logic [4:0]  day_value;
    logic [2:0]  weekday_value;
    logic [7:0]  event_char;
  } cmr_in_t;

  typedef struct packed {
    logic [7:0] led_index;
    logic [2:0] color_code;
    logic       last_of_run;
  } cmr_out_t;

  // One queue entry: either a month render or a lookup of one stored day.
  typedef struct packed {
    logic       is_lookup;
    logic [4:0] days;
    logic [2:0] first_wday;
    logic [4:0] today;
    logic [7:0] marker_led;
    logic       has_marker;
    logic [2:0] color;
  } cmr_cmd_t;

  function automatic logic [7:0] led_at(input logic [4:0] x, input logic [2:0] y);
    logic [7:0] cols;
    logic [7:0] led;
    begin
      cols = 8'(MATRIX_WIDTH) - 8'(x);
      if (x[0]) begin
        led = (cols - 8'd1) * 8'(MATRIX_HEIGHT) + 8'(y);
      end else begin
        led = cols * 8'(MATRIX_HEIGHT) - (8'(y) + 8'd1);
      end
      return led;
    end
  endfunction

endpackage

// ===== rtl/cmr_front.sv =====
module cmr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cmr_pkg::cmr_in_t   in_data,
  input  logic               q_full,
  output logic               push_valid,
  output cmr_pkg::cmr_cmd_t  push_cmd
);

  logic [4:0] mlen_r, mlen_nxt;
  logic [5:0] acc_r, acc_nxt;
  logic       has_digit_r, has_digit_nxt;
  logic       digits_ended_r, digits_ended_nxt;
  logic       personal_r, personal_nxt;
  logic       stopped_r, stopped_nxt;
  logic       token_start_r, token_start_nxt;

  logic        accept;
  logic [13:0] yr_prod;
  logic        div25;
  logic        leap;
  logic [4:0]  ndays;
  logic [2:0]  wday;
  logic [4:0]  steps;
  logic [2:0]  first_wday;
  logic [4:0]  mark_x;
  logic [2:0]  mark_y;
  logic [3:0]  digit;
  logic [9:0]  acc_sum;
  logic        lookup_hit;
  logic [7:0]  c;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign c        = in_data.event_char;

  // A multiple of 25 times the inverse of 25 modulo 2^14 lands at or below 655.
  assign yr_prod = in_data.year_value * 14'd7209;
  assign div25   = (yr_prod <= 14'd655);
  assign leap    = (in_data.year_value[1:0] == 2'd0) &&
                   (!div25 || (in_data.year_value[3:0] == 4'd0));

  always_comb begin
    case (in_data.month_value)
      4'd4, 4'd6, 4'd9, 4'd11: ndays = 5'd30;
      4'd2:                    ndays = leap ? 5'd29 : 5'd28;
      default:                 ndays = 5'd31;
    endcase
  end

  always_comb begin
    wday  = (in_data.weekday_value == 3'd0) ? cmr_pkg::WDAY_SATURDAY
                                            : in_data.weekday_value - 3'd1;
    steps = (in_data.day_value > 5'd1) ? in_data.day_value - 5'd1 : 5'd0;
    if (steps >= 5'd28) begin
      steps = steps - 5'd28;
    end
    if (steps >= 5'd14) begin
      steps = steps - 5'd14;
    end
    if (steps >= 5'd7) begin
      steps = steps - 5'd7;
    end
    if (wday >= steps[2:0]) begin
      first_wday = wday - steps[2:0];
    end else begin
      first_wday = wday + 3'd7 - steps[2:0];
    end
    if (in_data.month_value <= 4'd4) begin
      mark_x = 5'd9 + 5'(in_data.month_value);
      mark_y = 3'd2;
    end else begin
      mark_x = 5'(in_data.month_value) - 5'd2;
      mark_y = 3'd1;
    end
  end

  assign digit   = 4'(c - cmr_pkg::CHAR_ZERO);
  assign acc_sum = 10'(acc_r) * 10'd10 + 10'(digit);

  always_comb begin
    mlen_nxt         = mlen_r;
    acc_nxt          = acc_r;
    has_digit_nxt    = has_digit_r;
    digits_ended_nxt = digits_ended_r;
    personal_nxt     = personal_r;
    stopped_nxt      = stopped_r;
    token_start_nxt  = token_start_r;
    lookup_hit       = 1'b0;
    if (accept) begin
      if (in_data.opcode == cmr_pkg::OP_RENDER) begin
        mlen_nxt         = ndays;
        acc_nxt          = 6'd0;
        has_digit_nxt    = 1'b0;
        digits_ended_nxt = 1'b0;
        personal_nxt     = 1'b0;
        stopped_nxt      = 1'b0;
        token_start_nxt  = 1'b1;
      end else if (!stopped_r) begin
        if (c == cmr_pkg::CHAR_DASH) begin
          if (token_start_r) begin
            stopped_nxt = 1'b1;
          end else begin
            lookup_hit       = has_digit_r && (acc_r != 6'd0) && (acc_r <= 6'(mlen_r));
            acc_nxt          = 6'd0;
            has_digit_nxt    = 1'b0;
            digits_ended_nxt = 1'b0;
            token_start_nxt  = 1'b1;
          end
        end else if (token_start_r && (c == cmr_pkg::CHAR_X)) begin
          personal_nxt    = 1'b1;
          token_start_nxt = 1'b0;
        end else begin
          token_start_nxt = 1'b0;
          if ((c >= cmr_pkg::CHAR_ZERO) && (c <= cmr_pkg::CHAR_NINE)) begin
            if (!digits_ended_r) begin
              acc_nxt       = (acc_sum > 10'd63) ? 6'd63 : acc_sum[5:0];
              has_digit_nxt = 1'b1;
            end
          end else begin
            digits_ended_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    push_valid = accept && ((in_data.opcode == cmr_pkg::OP_RENDER) || lookup_hit);
    push_cmd.is_lookup  = (in_data.opcode == cmr_pkg::OP_EVENT);
    push_cmd.days       = (in_data.opcode == cmr_pkg::OP_EVENT) ? acc_r[4:0] : ndays;
    push_cmd.first_wday = first_wday;
    push_cmd.today      = in_data.day_value;
    push_cmd.marker_led = cmr_pkg::led_at(mark_x, mark_y);
    push_cmd.has_marker = (in_data.month_value >= 4'd1) && (in_data.month_value <= 4'd12);
    push_cmd.color      = personal_r ? cmr_pkg::COLOR_YELLOW : cmr_pkg::COLOR_CYAN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mlen_r         <= 5'd0;
      acc_r          <= 6'd0;
      has_digit_r    <= 1'b0;
      digits_ended_r <= 1'b0;
      personal_r     <= 1'b0;
      stopped_r      <= 1'b0;
      token_start_r  <= 1'b1;
    end else begin
      mlen_r         <= mlen_nxt;
      acc_r          <= acc_nxt;
      has_digit_r    <= has_digit_nxt;
      digits_ended_r <= digits_ended_nxt;
      personal_r     <= personal_nxt;
      stopped_r      <= stopped_nxt;
      token_start_r  <= token_start_nxt;
    end
  end

endmodule

// ===== rtl/cmr_queue.sv =====
module cmr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  cmr_pkg::cmr_cmd_t  push_cmd,
  output logic               q_full,
  output logic               q_valid,
  output cmr_pkg::cmr_cmd_t  q_cmd,
  input  logic               pop
);

  cmr_pkg::cmr_cmd_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign q_full  = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_cmd   = entry_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_valid;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + 2'(push_valid) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/cmr_back.sv =====
module cmr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  cmr_pkg::cmr_cmd_t  q_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output cmr_pkg::cmr_out_t  out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DAYS,
    ST_MARK
  } state_t;

  state_t            state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  cmr_pkg::cmr_out_t out_data_r, out_data_nxt;
  logic [4:0]        k_r, k_nxt;
  logic [4:0]        x_r, x_nxt;
  logic [2:0]        y_r, y_nxt;
  logic [2:0]        z_r, z_nxt;
  logic [4:0]        days_r, days_nxt;
  logic [4:0]        today_r, today_nxt;
  logic [7:0]        marker_r, marker_nxt;
  logic              has_marker_r, has_marker_nxt;
  logic [7:0]        day_table_r [32];

  logic       can_load;
  logic       tbl_we;
  logic [7:0] day_led;
  logic [2:0] day_color;

  assign can_load  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign day_led   = cmr_pkg::led_at(x_r, y_r);

  always_comb begin
    if (today_r == k_r) begin
      day_color = cmr_pkg::COLOR_GREEN;
    end else if ((z_r == cmr_pkg::WDAY_SUNDAY) || (z_r == cmr_pkg::WDAY_SATURDAY)) begin
      day_color = cmr_pkg::COLOR_BLUE;
    end else begin
      day_color = cmr_pkg::COLOR_RED;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    k_nxt          = k_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    z_nxt          = z_r;
    days_nxt       = days_r;
    today_nxt      = today_r;
    marker_nxt     = marker_r;
    has_marker_nxt = has_marker_r;
    pop            = 1'b0;
    tbl_we         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && can_load) begin
          pop = 1'b1;
          if (q_cmd.is_lookup) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.led_index   = day_table_r[q_cmd.days];
            out_data_nxt.color_code  = q_cmd.color;
            out_data_nxt.last_of_run = 1'b1;
          end else begin
            k_nxt          = 5'd1;
            x_nxt          = cmr_pkg::FIRST_COLUMN;
            y_nxt          = cmr_pkg::FIRST_ROW;
            z_nxt          = q_cmd.first_wday;
            days_nxt       = q_cmd.days;
            today_nxt      = q_cmd.today;
            marker_nxt     = q_cmd.marker_led;
            has_marker_nxt = q_cmd.has_marker;
            state_nxt      = ST_DAYS;
          end
        end
      end
      ST_DAYS: begin
        if (can_load) begin
          tbl_we                   = 1'b1;
          out_valid_nxt            = 1'b1;
          out_data_nxt.led_index   = day_led;
          out_data_nxt.color_code  = day_color;
          out_data_nxt.last_of_run = !has_marker_r && (k_r == days_r);
          k_nxt                    = k_r + 5'd1;
          if (z_r == cmr_pkg::WDAY_SATURDAY) begin
            x_nxt = x_r - 5'd6;
            y_nxt = y_r - 3'd1;
            z_nxt = cmr_pkg::WDAY_SUNDAY;
          end else begin
            x_nxt = x_r + 5'd1;
            z_nxt = z_r + 3'd1;
          end
          if (k_r == days_r) begin
            state_nxt = has_marker_r ? ST_MARK : ST_IDLE;
          end
        end
      end
      ST_MARK: begin
        if (can_load) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.led_index   = marker_r;
          out_data_nxt.color_code  = cmr_pkg::COLOR_BLUE;
          out_data_nxt.last_of_run = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r   <= out_data_nxt;
    k_r          <= k_nxt;
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    z_r          <= z_nxt;
    days_r       <= days_nxt;
    today_r      <= today_nxt;
    marker_r     <= marker_nxt;
    has_marker_r <= has_marker_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) begin
        day_table_r[i] <= 8'd0;
      end
    end else if (tbl_we) begin
      day_table_r[k_r] <= day_led;
    end
  end

endmodule

// ===== rtl/calendar_matrix_renderer.sv =====
// Channel  Direction  Handshake             Beat
// in_      input      in_valid / in_ready   cmr_in_t: render date or one event byte
// out_     output     out_valid / out_ready cmr_out_t: LED index, color, last flag
//
// An event byte is parsed in the front as it is accepted; a completed token that names a
// stored day is queued and, once the back is idle, presented from the output register.
// A render occupies the back sequencer for a setup step, one beat per day and, for months
// 1 to 12, a month marker beat, while the two-entry queue keeps taking beats.
// Synchronous active-low reset clears the parser, queue, sequencer and day table.
// in_ready drops only when the queue is full; out_ready low holds the output register.
module calendar_matrix_renderer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cmr_pkg::cmr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cmr_pkg::cmr_out_t out_data
);

  logic              q_full;
  logic              push_valid;
  cmr_pkg::cmr_cmd_t push_cmd;
  logic              q_valid;
  cmr_pkg::cmr_cmd_t q_cmd;
  logic              pop;

  cmr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  cmr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .q_full     (q_full),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .pop        (pop)
  );

  cmr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/cmr_checker.sv =====
module cmr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input cmr_pkg::cmr_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input cmr_pkg::cmr_out_t out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input beat changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_color_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.color_code <= cmr_pkg::COLOR_YELLOW)
    else $error("color code out of range");

  a_event_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.color_code == cmr_pkg::COLOR_CYAN) ||
                  (out_data.color_code == cmr_pkg::COLOR_YELLOW)) |-> out_data.last_of_run)
    else $error("event beat without last flag");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind calendar_matrix_renderer cmr_checker u_cmr_checker (.*);

// ===== verif/calendar_led_checker.sv =====
`timescale 1ns / 1ps

module calendar_led_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  cmr_pkg::cmr_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  cmr_pkg::cmr_out_t out_data,
  output int                mismatches,
  output int                outstanding
);

  cmr_pkg::cmr_out_t expected_leds[$];
  cmr_pkg::cmr_out_t want;
  logic [7:0]        day_leds[32];
  logic [5:0]        month_days_held;
  logic [5:0]        day_number;
  logic              has_digit;
  logic              digits_done;
  logic              personal;
  logic              stopped;
  logic              token_fresh;
  int                errors = 0;

  assign mismatches = errors;

  function automatic logic [7:0] matrix_led(input int x, input int y);
    int v;
    if (x % 2 == 1) begin
      v = cmr_pkg::MATRIX_HEIGHT * (cmr_pkg::MATRIX_WIDTH - (x + 1)) + y;
    end else begin
      v = cmr_pkg::MATRIX_HEIGHT * (cmr_pkg::MATRIX_WIDTH - x) - (y + 1);
    end
    return v[7:0];
  endfunction

  function automatic int month_length_of(input int yr, input int m);
    bit leap;
    leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    if (m == 2) begin
      return leap ? 29 : 28;
    end
    return 31;
  endfunction

  task automatic restart_parser();
    day_number  = '0;
    has_digit   = 1'b0;
    digits_done = 1'b0;
    personal    = 1'b0;
    stopped     = 1'b0;
    token_fresh = 1'b1;
  endtask

  task automatic queue_led(input logic [7:0] led, input logic [2:0] color, input logic last);
    cmr_pkg::cmr_out_t r;
    r.led_index   = led;
    r.color_code  = color;
    r.last_of_run = last;
    expected_leds.push_back(r);
  endtask

  task automatic render_month(input cmr_pkg::cmr_in_t b);
    int         yr;
    int         m;
    int         d;
    int         wd;
    int         nd;
    int         steps;
    int         z;
    int         x;
    int         y;
    bit         marker;
    logic [7:0] led;
    logic [7:0] mark_led;
    logic [2:0] color;
    yr     = int'(b.year_value);
    m      = int'(b.month_value);
    d      = int'(b.day_value);
    wd     = int'(b.weekday_value);
    nd     = month_length_of(yr, m);
    steps  = (d > 1) ? (d - 1) % 7 : 0;
    z      = ((wd + 6) % 7 + 7 - steps) % 7;
    x      = int'(cmr_pkg::FIRST_COLUMN);
    y      = int'(cmr_pkg::FIRST_ROW);
    marker = (m >= 1 && m <= 12);
    restart_parser();
    month_days_held = nd[5:0];
    for (int k = 1; k <= nd; k++) begin
      led = matrix_led(x, y);
      day_leds[k[4:0]] = led;
      if (d == k) begin
        color = cmr_pkg::COLOR_GREEN;
      end else if (z == int'(cmr_pkg::WDAY_SUNDAY) || z == int'(cmr_pkg::WDAY_SATURDAY)) begin
        color = cmr_pkg::COLOR_BLUE;
      end else begin
        color = cmr_pkg::COLOR_RED;
      end
      queue_led(led, color, !marker && k == nd);
      if (z == int'(cmr_pkg::WDAY_SATURDAY)) begin
        x = x - 6;
        y = y - 1;
        z = int'(cmr_pkg::WDAY_SUNDAY);
      end else begin
        x = x + 1;
        z = z + 1;
      end
    end
    if (marker) begin
      mark_led = (m <= 4) ? matrix_led(9 + m, 2) : matrix_led(m - 2, 1);
      queue_led(mark_led, cmr_pkg::COLOR_BLUE, 1'b1);
    end
  endtask

  task automatic parse_event_char(input logic [7:0] c);
    int v;
    if (stopped) begin
      return;
    end
    if (c == cmr_pkg::CHAR_DASH) begin
      if (token_fresh) begin
        stopped = 1'b1;
        return;
      end
      if (has_digit && day_number >= 1 && day_number <= month_days_held) begin
        queue_led(day_leds[day_number[4:0]],
                  personal ? cmr_pkg::COLOR_YELLOW : cmr_pkg::COLOR_CYAN, 1'b1);
      end
      day_number  = '0;
      has_digit   = 1'b0;
      digits_done = 1'b0;
      token_fresh = 1'b1;
    end else if (token_fresh && c == cmr_pkg::CHAR_X) begin
      personal    = 1'b1;
      token_fresh = 1'b0;
    end else begin
      token_fresh = 1'b0;
      if (c >= cmr_pkg::CHAR_ZERO && c <= cmr_pkg::CHAR_NINE) begin
        if (!digits_done) begin
          v          = int'(day_number) * 10 + int'(c) - int'(cmr_pkg::CHAR_ZERO);
          day_number = (v > 63) ? 6'd63 : v[5:0];
          has_digit  = 1'b1;
        end
      end else begin
        digits_done = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) begin
        day_leds[i] = '0;
      end
      month_days_held = '0;
      restart_parser();
      expected_leds.delete();
    end else begin
      // The block registers every result, so a beat leaving now cannot
      // belong to an item entering at this same edge.
      if (out_valid && out_ready) begin
        if (expected_leds.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected beat: led %0d color %0d last %0b", out_data.led_index,
                     out_data.color_code, out_data.last_of_run);
          end
        end else begin
          want = expected_leds.pop_front();
          if (out_data.led_index !== want.led_index || out_data.color_code !== want.color_code
              || out_data.last_of_run !== want.last_of_run) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected led %0d color %0d last %0b, got %0d %0d %0b",
                       want.led_index, want.color_code, want.last_of_run, out_data.led_index,
                       out_data.color_code, out_data.last_of_run);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.opcode == cmr_pkg::OP_RENDER) begin
          render_month(in_data);
        end else begin
          parse_event_char(in_data.event_char);
        end
      end
    end
    outstanding <= expected_leds.size();
  end

endmodule

// ===== verif/tb_calendar_matrix_renderer.sv =====
`timescale 1ns / 1ps

module tb_calendar_matrix_renderer;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 120;
  localparam int NOISE_NONE   = 0;
  localparam int NOISE_LEAD   = 1;
  localparam int NOISE_TRAIL  = 2;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  cmr_pkg::cmr_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  cmr_pkg::cmr_out_t out_data;
  int                mismatches;
  int                outstanding;
  int                cycles = 0;
  int                items_sent = 0;
  bit                idle_in = 1'b0;
  bit                idle_out = 1'b0;

  calendar_matrix_renderer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  calendar_led_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL calendar_matrix_renderer");
      $finish;
    end
  end

  initial begin : result_sink
    int gap;
    forever begin
      gap = idle_out ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_beat(input cmr_pkg::cmr_in_t b);
    int gap;
    gap = idle_in ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_event(input logic [7:0] c);
    cmr_pkg::cmr_in_t b;
    b.opcode        = cmr_pkg::OP_EVENT;
    b.year_value    = 14'($urandom_range(0, 16383));
    b.month_value   = 4'($urandom_range(0, 15));
    b.day_value     = 5'($urandom_range(0, 31));
    b.weekday_value = 3'($urandom_range(0, 7));
    b.event_char    = c;
    send_beat(b);
  endtask

  task automatic send_render(input int yr, input int m, input int d, input int wd);
    cmr_pkg::cmr_in_t b;
    b.opcode        = cmr_pkg::OP_RENDER;
    b.year_value    = 14'(yr);
    b.month_value   = 4'(m);
    b.day_value     = 5'(d);
    b.weekday_value = 3'(wd);
    b.event_char    = 8'($urandom_range(0, 255));
    send_beat(b);
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == cmr_pkg::CHAR_DASH) begin
      c = cmr_pkg::CHAR_X;
    end
    return c;
  endfunction

  task automatic send_token(input int v, input bit personal, input int noise_at);
    if (personal) begin
      send_event(cmr_pkg::CHAR_X);
    end
    if (noise_at == NOISE_LEAD) begin
      send_event(noise_byte());
    end
    if (v >= 100) begin
      send_event(cmr_pkg::CHAR_ZERO + 8'((v / 100) % 10));
    end
    if (v >= 10) begin
      send_event(cmr_pkg::CHAR_ZERO + 8'((v / 10) % 10));
    end
    send_event(cmr_pkg::CHAR_ZERO + 8'(v % 10));
    if (noise_at == NOISE_TRAIL) begin
      send_event(noise_byte());
    end
    send_event(cmr_pkg::CHAR_DASH);
  endtask

  initial begin
    int yr;
    int m;
    int d;
    int wd;
    int ntok;
    int pick;
    int day;
    int noise_at;
    repeat (11) @(posedge clk);
    rst_n    <= 1'b1;
    idle_in  <= 1'b1;
    idle_out <= 1'b1;

    send_token(7, 1'b0, NOISE_NONE);
    send_render(0, 15, 0, 0);
    send_token(31, 1'b0, NOISE_NONE);
    send_render(16383, 2, 31, 7);
    send_token(2, 1'b1, NOISE_NONE);
    send_token(99, 1'b0, NOISE_NONE);
    send_event("1");
    send_event(" ");
    send_event("5");
    send_event(cmr_pkg::CHAR_DASH);
    send_event(cmr_pkg::CHAR_DASH);
    send_token(3, 1'b0, NOISE_NONE);
    send_render(2000, 2, 29, 3);
    send_render(1900, 12, 1, 1);
    send_render(2024, 4, 30, 2);
    send_token(0, 1'b0, NOISE_NONE);

    while (items_sent < RANDOM_ITEMS) begin
      idle_in  <= ($urandom_range(0, 3) != 0);
      idle_out <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        yr = $urandom_range(0, 16383);
        m  = $urandom_range(0, 15);
        d  = $urandom_range(0, 31);
        wd = $urandom_range(0, 7);
      end else begin
        yr = ($urandom_range(0, 3) == 0) ? 100 * $urandom_range(0, 99) : $urandom_range(0, 9999);
        m  = $urandom_range(1, 12);
        d  = $urandom_range(1, 31);
        wd = $urandom_range(1, 7);
      end
      send_render(yr, m, d, wd);
      ntok = $urandom_range(1, 6);
      repeat (ntok) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          day = $urandom_range(1, 31);
        end else if (pick == 8) begin
          day = 0;
        end else begin
          day = $urandom_range(32, 999);
        end
        pick = $urandom_range(0, 9);
        noise_at = (pick == 0) ? NOISE_LEAD : (pick == 1) ? NOISE_TRAIL : NOISE_NONE;
        send_token(day, $urandom_range(0, 7) == 0, noise_at);
      end
      if ($urandom_range(0, 5) == 0) begin
        send_event(cmr_pkg::CHAR_DASH);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS calendar_matrix_renderer");
    end else begin
      $display("FAIL calendar_matrix_renderer");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cmr_pkg.sv
rtl/cmr_front.sv
rtl/cmr_queue.sv
rtl/cmr_back.sv
rtl/calendar_matrix_renderer.sv
rtl/cmr_checker.sv
verif/calendar_led_checker.sv
verif/tb_calendar_matrix_renderer.sv
